// ===== hdl/dnsqp_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsqp_pkg
// Shared types and constants for the DNS query question parser.
// ----------------------------------------------------------------------------
package dnsqp_pkg;

  localparam int MAX_LABEL = 63;
  localparam int MAX_NAME  = 255;
  localparam int HDR_BYTES = 12;

  // header byte offsets
  localparam logic [15:0] POS_FLAGS   = 16'd2;
  localparam logic [15:0] POS_CNT_LO  = 16'd4;
  localparam logic [15:0] POS_QDCNT   = 16'd5;
  localparam logic [15:0] POS_HDR_END = 16'(HDR_BYTES - 1);
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  // type and class take four bytes after the zero label
  localparam logic [5:0] TC_BYTES = 6'd4;

  localparam logic [15:0] CLS_INET     = 16'd1;
  localparam logic [15:0] CLS_CHAOSNET = 16'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMERR = 2'd1,
    ST_NOTIMPL = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_LENGTH    = 6'b000010,
    PH_CHARS     = 6'b000100,
    PH_TYPECLASS = 6'b001000,
    PH_DONE      = 6'b010000,
    PH_SKIP      = 6'b100000
  } phase_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic        dot_follows;
    status_t     status;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [7:0]  name_len;
    logic [7:0]  wire_name_len;
  } result_t;

endpackage

// ===== hdl/dns_query_question_parser_top.sv =====
// ----------------------------------------------------------------------------
// dns_query_question_parser_top
// Byte-serial DNS query header and question section parser.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while in_stall is low: each byte is
// decided by the parse state and that input beat alone, in one pass from
// the state registers into the result register. Name characters come out
// lowercased as they arrive; the final byte yields one verdict beat and
// returns the parser to its header state for the next message. Results pass
// through an output register backed by a one-entry skid register, so input
// stall rises only when both hold a beat the downstream has not taken.
module dns_query_question_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_msg_len,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_name_char,
  output logic        out_dot_follows,
  output logic [1:0]  out_status,
  output logic [15:0] out_query_type,
  output logic [15:0] out_query_class,
  output logic [7:0]  out_name_len,
  output logic [7:0]  out_wire_name_len
);

  dnsqp_pkg::phase_t  phase_r, phase_nxt;
  dnsqp_pkg::status_t verdict_r, verdict_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [5:0]  lab_rem_r, lab_rem_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] class_r, class_nxt;
  logic [7:0]  dot_len_r, dot_len_nxt;
  logic [7:0]  enc_len_r, enc_len_nxt;

  dnsqp_pkg::result_t res, out_r, skid_r;
  logic res_valid;
  logic out_valid_r, skid_valid_r;
  logic acc, out_fire, emit;

  logic signed [17:0] avail_s;
  logic [8:0]  p9;
  logic [9:0]  sum10;
  logic [7:0]  ch;
  logic [15:0] class_fin;
  dnsqp_pkg::status_t st;

  assign acc      = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign avail_s = $signed({2'b00, in_msg_len}) - 18'sd12;
  assign p9      = {1'b0, enc_len_r} + 9'd1;
  assign sum10   = {1'b0, p9} + {2'b00, in_data_byte};
  assign ch      = (in_data_byte > 8'h40 && in_data_byte < 8'h5B) ?
                   (in_data_byte | 8'h20) : in_data_byte;
  assign class_fin = {class_r[15:8], in_data_byte};

  always_comb begin
    phase_nxt   = phase_r;
    verdict_nxt = verdict_r;
    pos_nxt     = (pos_r != dnsqp_pkg::POS_MAX) ? pos_r + 16'd1 : pos_r;
    lab_rem_nxt = lab_rem_r;
    type_nxt    = type_r;
    class_nxt   = class_r;
    dot_len_nxt = dot_len_r;
    enc_len_nxt = enc_len_r;
    emit        = 1'b0;

    unique case (phase_r)
      dnsqp_pkg::PH_HEADER: begin
        if (pos_r == dnsqp_pkg::POS_FLAGS && verdict_r == dnsqp_pkg::ST_OK) begin
          if (in_data_byte[7] || in_data_byte[1]) begin
            verdict_nxt = dnsqp_pkg::ST_FORMERR;
          end else if (in_data_byte[6:3] != 4'd0) begin
            verdict_nxt = dnsqp_pkg::ST_NOTIMPL;
          end
        end
        if (pos_r >= dnsqp_pkg::POS_CNT_LO && pos_r <= dnsqp_pkg::POS_HDR_END &&
            verdict_r == dnsqp_pkg::ST_OK) begin
          if (in_data_byte != ((pos_r == dnsqp_pkg::POS_QDCNT) ? 8'd1 : 8'd0)) begin
            verdict_nxt = dnsqp_pkg::ST_FORMERR;
          end
        end
        if (pos_r == dnsqp_pkg::POS_HDR_END) begin
          phase_nxt = (verdict_nxt != dnsqp_pkg::ST_OK) ? dnsqp_pkg::PH_SKIP :
                                                          dnsqp_pkg::PH_LENGTH;
        end
      end
      dnsqp_pkg::PH_LENGTH: begin
        // compression pointer or oversize label
        if (in_data_byte[7:6] != 2'b00 || in_data_byte > 8'(dnsqp_pkg::MAX_LABEL)) begin
          verdict_nxt = dnsqp_pkg::ST_FORMERR;
          phase_nxt   = dnsqp_pkg::PH_SKIP;
        end else if (in_data_byte == 8'd0) begin
          enc_len_nxt = p9[7:0];
          if ($signed({9'b0, p9}) + 18'sd4 > avail_s) begin
            verdict_nxt = dnsqp_pkg::ST_FORMERR;
            phase_nxt   = dnsqp_pkg::PH_SKIP;
          end else begin
            lab_rem_nxt = dnsqp_pkg::TC_BYTES;
            phase_nxt   = dnsqp_pkg::PH_TYPECLASS;
          end
        end else if ($signed({8'b0, sum10}) >= avail_s) begin
          verdict_nxt = dnsqp_pkg::ST_FORMERR;
          phase_nxt   = dnsqp_pkg::PH_SKIP;
        end else if ({1'b0, sum10} + 11'd1 > 11'(dnsqp_pkg::MAX_NAME)) begin
          verdict_nxt = dnsqp_pkg::ST_FORMERR;
          phase_nxt   = dnsqp_pkg::PH_SKIP;
        end else begin
          enc_len_nxt = p9[7:0];
          lab_rem_nxt = in_data_byte[5:0];
          phase_nxt   = dnsqp_pkg::PH_CHARS;
        end
      end
      dnsqp_pkg::PH_CHARS: begin
        emit        = 1'b1;
        enc_len_nxt = enc_len_r + 8'd1;
        lab_rem_nxt = lab_rem_r - 6'd1;
        if (lab_rem_r == 6'd1) begin
          // label ends, count the dot too
          dot_len_nxt = dot_len_r + 8'd2;
          phase_nxt   = dnsqp_pkg::PH_LENGTH;
        end else begin
          dot_len_nxt = dot_len_r + 8'd1;
        end
      end
      dnsqp_pkg::PH_TYPECLASS: begin
        lab_rem_nxt = lab_rem_r - 6'd1;
        if (lab_rem_r == 6'd4) begin
          type_nxt = {in_data_byte, 8'h00};
        end else if (lab_rem_r == 6'd3) begin
          type_nxt = {type_r[15:8], in_data_byte};
        end else if (lab_rem_r == 6'd2) begin
          class_nxt = {in_data_byte, 8'h00};
        end else begin
          class_nxt = class_fin;
          if (class_fin != dnsqp_pkg::CLS_INET && class_fin != dnsqp_pkg::CLS_CHAOSNET) begin
            verdict_nxt = dnsqp_pkg::ST_NOTIMPL;
          end
          phase_nxt = dnsqp_pkg::PH_DONE;
        end
      end
      dnsqp_pkg::PH_DONE, dnsqp_pkg::PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (phase_nxt == dnsqp_pkg::PH_DONE || verdict_nxt != dnsqp_pkg::ST_OK) begin
      st = verdict_nxt;
    end else begin
      st = dnsqp_pkg::ST_FORMERR;
    end

    res = '0;
    if (in_last) begin
      res.kind   = dnsqp_pkg::KIND_VERDICT;
      res.status = st;
      if (st == dnsqp_pkg::ST_OK) begin
        res.query_type    = type_nxt;
        res.query_class   = class_nxt;
        res.name_len      = dot_len_nxt;
        res.wire_name_len = enc_len_nxt;
      end
    end else begin
      res.kind        = dnsqp_pkg::KIND_CHAR;
      res.status      = dnsqp_pkg::ST_OK;
      res.name_char   = ch;
      res.dot_follows = (phase_r == dnsqp_pkg::PH_CHARS) && (lab_rem_r == 6'd1);
    end
    res_valid = acc && (in_last || emit);
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_last)) begin
      phase_r   <= dnsqp_pkg::PH_HEADER;
      verdict_r <= dnsqp_pkg::ST_OK;
      pos_r     <= '0;
      lab_rem_r <= '0;
      type_r    <= '0;
      class_r   <= '0;
      dot_len_r <= '0;
      enc_len_r <= '0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      verdict_r <= verdict_nxt;
      pos_r     <= pos_nxt;
      lab_rem_r <= lab_rem_nxt;
      type_r    <= type_nxt;
      class_r   <= class_nxt;
      dot_len_r <= dot_len_nxt;
      enc_len_r <= enc_len_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_name_char     = out_r.name_char;
  assign out_dot_follows   = out_r.dot_follows;
  assign out_status        = out_r.status;
  assign out_query_type    = out_r.query_type;
  assign out_query_class   = out_r.query_class;
  assign out_name_len      = out_r.name_len;
  assign out_wire_name_len = out_r.wire_name_len;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output beat");

  a_chars_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dnsqp_pkg::PH_CHARS) |-> (lab_rem_r != 6'd0))
    else $error("character phase with no label bytes left");

  a_skip_has_fault : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dnsqp_pkg::PH_SKIP) |-> (verdict_r != dnsqp_pkg::ST_OK))
    else $error("skip phase without a latched fault");

  a_last_restarts : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last) |=> (phase_r == dnsqp_pkg::PH_HEADER && pos_r == 16'd0))
    else $error("parser did not restart after final beat");

endmodule

// ===== test/dns_query_question_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_question_parser_checker
// Watches both channels of the question parser, predicts every result beat
// from the accepted message bytes and compares each result field by field.
// ----------------------------------------------------------------------------
module dns_query_question_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_msg_len,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [7:0]  out_name_char,
  input  logic        out_dot_follows,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_query_type,
  input  logic [15:0] out_query_class,
  input  logic [7:0]  out_name_len,
  input  logic [7:0]  out_wire_name_len,
  output int          fail_count,
  output int          n_pending,
  output int          n_chars,
  output int          n_verdicts,
  output int          n_ok
);

  // parser state as the block should hold it
  logic [15:0]        pos_q;
  dnsqp_pkg::phase_t  phase_q;
  logic [5:0]         label_left;
  dnsqp_pkg::status_t verdict_q;
  logic [15:0]        type_q;
  logic [15:0]        class_q;
  logic [7:0]         dotted_len_q;
  logic [7:0]         wire_len_q;

  dnsqp_pkg::result_t pending_results[$];
  int      errs;
  int      beat_no;
  int      chars_seen;
  int      verdicts_seen;
  int      ok_seen;

  initial begin
    errs = 0;
    beat_no = 0;
    chars_seen = 0;
    verdicts_seen = 0;
    ok_seen = 0;
  end

  task automatic clear_parse_state();
    pos_q = '0;
    phase_q = dnsqp_pkg::PH_HEADER;
    label_left = '0;
    verdict_q = dnsqp_pkg::ST_OK;
    type_q = '0;
    class_q = '0;
    dotted_len_q = '0;
    wire_len_q = '0;
  endtask

  task automatic latch_format_error();
    verdict_q = dnsqp_pkg::ST_FORMERR;
    phase_q = dnsqp_pkg::PH_SKIP;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic [15:0] mlen, input logic lst);
    int                 avail;
    int                 p;
    int                 len;
    logic               emit_char;
    logic [7:0]         ch;
    logic               dot;
    dnsqp_pkg::status_t st;
    dnsqp_pkg::result_t r;
    avail = int'(mlen) - dnsqp_pkg::HDR_BYTES;
    emit_char = 1'b0;
    ch = '0;
    dot = 1'b0;
    case (phase_q)
      dnsqp_pkg::PH_HEADER: begin
        if (pos_q == dnsqp_pkg::POS_FLAGS && verdict_q == dnsqp_pkg::ST_OK) begin
          // qr or tc set, then opcode
          if (b[7] || b[1]) verdict_q = dnsqp_pkg::ST_FORMERR;
          else if (b[6:3] != 4'd0) verdict_q = dnsqp_pkg::ST_NOTIMPL;
        end
        if (pos_q >= dnsqp_pkg::POS_CNT_LO && pos_q <= dnsqp_pkg::POS_HDR_END &&
            verdict_q == dnsqp_pkg::ST_OK) begin
          if (b != ((pos_q == dnsqp_pkg::POS_QDCNT) ? 8'd1 : 8'd0))
            verdict_q = dnsqp_pkg::ST_FORMERR;
        end
        if (pos_q == dnsqp_pkg::POS_HDR_END)
          phase_q = (verdict_q != dnsqp_pkg::ST_OK) ? dnsqp_pkg::PH_SKIP :
                                                      dnsqp_pkg::PH_LENGTH;
      end
      dnsqp_pkg::PH_LENGTH: begin
        p = int'(wire_len_q) + 1;
        len = int'(b);
        // a compression pointer has its top bits set, so it is over the limit too
        if (len > dnsqp_pkg::MAX_LABEL) begin
          latch_format_error();
        end else if (len == 0) begin
          wire_len_q = 8'(p);
          if (p + 4 > avail) begin
            latch_format_error();
          end else begin
            label_left = dnsqp_pkg::TC_BYTES;
            phase_q = dnsqp_pkg::PH_TYPECLASS;
          end
        end else if (p + len >= avail) begin
          latch_format_error();
        end else if (p + len + 1 > dnsqp_pkg::MAX_NAME) begin
          latch_format_error();
        end else begin
          wire_len_q = 8'(p);
          label_left = 6'(len);
          phase_q = dnsqp_pkg::PH_CHARS;
        end
      end
      dnsqp_pkg::PH_CHARS: begin
        ch = (b > 8'h40 && b < 8'h5B) ? (b | 8'h20) : b;
        wire_len_q = wire_len_q + 8'd1;
        dotted_len_q = dotted_len_q + 8'd1;
        label_left = label_left - 6'd1;
        if (label_left == 6'd0) begin
          dot = 1'b1;
          dotted_len_q = dotted_len_q + 8'd1;
          phase_q = dnsqp_pkg::PH_LENGTH;
        end
        emit_char = 1'b1;
      end
      dnsqp_pkg::PH_TYPECLASS: begin
        if (label_left == dnsqp_pkg::TC_BYTES) begin
          type_q = {b, 8'h00};
        end else if (label_left == 6'd3) begin
          type_q[7:0] = b;
        end else if (label_left == 6'd2) begin
          class_q = {b, 8'h00};
        end else begin
          class_q[7:0] = b;
          if (class_q != dnsqp_pkg::CLS_INET && class_q != dnsqp_pkg::CLS_CHAOSNET)
            verdict_q = dnsqp_pkg::ST_NOTIMPL;
          phase_q = dnsqp_pkg::PH_DONE;
        end
        label_left = label_left - 6'd1;
      end
      default: ;
    endcase

    if (pos_q != dnsqp_pkg::POS_MAX) pos_q = pos_q + 16'd1;

    if (lst) begin
      if (phase_q == dnsqp_pkg::PH_DONE) st = verdict_q;
      else st = (verdict_q != dnsqp_pkg::ST_OK) ? verdict_q : dnsqp_pkg::ST_FORMERR;
      r = '0;
      r.kind = dnsqp_pkg::KIND_VERDICT;
      r.status = st;
      if (st == dnsqp_pkg::ST_OK) begin
        r.query_type = type_q;
        r.query_class = class_q;
        r.name_len = dotted_len_q;
        r.wire_name_len = wire_len_q;
      end
      pending_results.push_back(r);
      clear_parse_state();
    end else if (emit_char) begin
      r = '0;
      r.kind = dnsqp_pkg::KIND_CHAR;
      r.name_char = ch;
      r.dot_follows = dot;
      pending_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s on result beat %0d: got 0x%0h, expected 0x%0h",
             what, beat_no, got, want);
    errs++;
  endtask

  always @(posedge clk) begin : monitor
    dnsqp_pkg::result_t want;
    if (!rst_n) begin
      clear_parse_state();
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_msg_len, in_last);
      if (out_valid && !out_stall) begin
        beat_no++;
        if (pending_results.size() == 0) begin
          report_mismatch("beat with nothing expected", out_kind, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
          if (out_name_char !== want.name_char)
            report_mismatch("name_char", out_name_char, want.name_char);
          if (out_dot_follows !== want.dot_follows)
            report_mismatch("dot_follows", out_dot_follows, want.dot_follows);
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_query_type !== want.query_type)
            report_mismatch("query_type", out_query_type, want.query_type);
          if (out_query_class !== want.query_class)
            report_mismatch("query_class", out_query_class, want.query_class);
          if (out_name_len !== want.name_len)
            report_mismatch("name_len", out_name_len, want.name_len);
          if (out_wire_name_len !== want.wire_name_len)
            report_mismatch("wire_name_len", out_wire_name_len, want.wire_name_len);
          if (want.kind == dnsqp_pkg::KIND_CHAR) begin
            chars_seen++;
          end else begin
            verdicts_seen++;
            if (want.status == dnsqp_pkg::ST_OK) ok_seen++;
          end
        end
      end
    end
    fail_count <= errs;
    n_pending <= pending_results.size();
    n_chars <= chars_seen;
    n_verdicts <= verdicts_seen;
    n_ok <= ok_seen;
  end

endmodule

// ===== test/dns_query_question_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_question_parser_top_test
// Drives DNS query messages byte by byte into the question parser: a directed
// set of header, label and length corner cases, then random well-formed and
// damaged messages under random idling and one long output hold.
// ----------------------------------------------------------------------------
module dns_query_question_parser_top_test;

  localparam int ITEMS     = 1100;
  localparam int LONG_HOLD = 200;
  localparam int QUIET_MAX = 2000;
  localparam int DRAIN     = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_msg_len = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  out_name_char;
  logic        out_dot_follows;
  logic [1:0]  out_status;
  logic [15:0] out_query_type;
  logic [15:0] out_query_class;
  logic [7:0]  out_name_len;
  logic [7:0]  out_wire_name_len;

  int fail_count;
  int n_pending;
  int n_chars;
  int n_verdicts;
  int n_ok;

  logic [7:0] msg_q[$];
  int         bytes_sent = 0;
  int         msgs_sent = 0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  bit         long_hold_req = 1'b0;
  bit         long_hold_done = 1'b0;
  int         rx_hold = 0;

  always #5 clk = ~clk;

  dns_query_question_parser_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_msg_len       (in_msg_len),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_name_char    (out_name_char),
    .out_dot_follows  (out_dot_follows),
    .out_status       (out_status),
    .out_query_type   (out_query_type),
    .out_query_class  (out_query_class),
    .out_name_len     (out_name_len),
    .out_wire_name_len(out_wire_name_len)
  );

  dns_query_question_parser_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_msg_len       (in_msg_len),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_name_char    (out_name_char),
    .out_dot_follows  (out_dot_follows),
    .out_status       (out_status),
    .out_query_type   (out_query_type),
    .out_query_class  (out_query_class),
    .out_name_len     (out_name_len),
    .out_wire_name_len(out_wire_name_len),
    .fail_count       (fail_count),
    .n_pending        (n_pending),
    .n_chars          (n_chars),
    .n_verdicts       (n_verdicts),
    .n_ok             (n_ok)
  );

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      out_stall <= 1'b1;
      rx_hold = LONG_HOLD - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_hold = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("no beat moved for %0d cycles", QUIET_MAX);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_header(input logic [7:0] flags);
    msg_q.push_back(8'($urandom));
    msg_q.push_back(8'($urandom));
    msg_q.push_back(flags);
    msg_q.push_back(8'($urandom));
    // qdcount 1, all other counts 0
    msg_q.push_back(8'h00);
    msg_q.push_back(8'h01);
    repeat (6) msg_q.push_back(8'h00);
  endtask

  task automatic push_label(input int n);
    int i;
    msg_q.push_back(8'(n));
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: msg_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        1: msg_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        2: msg_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        default: msg_q.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic push_tail(input logic [15:0] qtype, input logic [15:0] qclass);
    msg_q.push_back(8'h00);
    msg_q.push_back(qtype[15:8]);
    msg_q.push_back(qtype[7:0]);
    msg_q.push_back(qclass[15:8]);
    msg_q.push_back(qclass[7:0]);
  endtask

  task automatic trim_to(input int n);
    while (msg_q.size() > n) void'(msg_q.pop_back());
  endtask

  function automatic logic [7:0] ok_flags();
    logic [7:0] f;
    f = 8'($urandom);
    f[7] = 1'b0;
    f[6:3] = 4'd0;
    f[1] = 1'b0;
    return f;
  endfunction

  task automatic send_msg(input logic [15:0] mlen);
    int i;
    for (i = 0; i < msg_q.size(); i++) begin
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= msg_q[i];
      in_msg_len <= mlen;
      in_last <= (i == msg_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
    msg_q.delete();
    msgs_sent++;
  endtask

  task automatic send_random_msg();
    int         nlab;
    int         i;
    int         len;
    int         sz;
    logic [15:0] mlen;
    logic [15:0] qclass;
    push_header(ok_flags());
    if ($urandom_range(0, 59) == 0) begin
      // near the name length limit: fits at 61, overflows above
      repeat (3) push_label(dnsqp_pkg::MAX_LABEL);
      push_label($urandom_range(60, 63));
    end else begin
      nlab = $urandom_range(0, 4);
      for (i = 0; i < nlab; i++) begin
        len = ($urandom_range(0, 29) == 0) ? dnsqp_pkg::MAX_LABEL : $urandom_range(1, 12);
        push_label(len);
      end
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: qclass = dnsqp_pkg::CLS_INET;
      5, 6, 7: qclass = dnsqp_pkg::CLS_CHAOSNET;
      default: qclass = 16'($urandom);
    endcase
    push_tail(($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom), qclass);
    repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom));
    sz = msg_q.size();
    mlen = 16'(sz);
    if ($urandom_range(0, 99) >= 70) begin
      case ($urandom_range(0, 5))
        0: begin
          i = $urandom_range(2, 11);
          msg_q[i] = msg_q[i] ^ (8'h01 << $urandom_range(0, 7));
        end
        1: msg_q[12] = 8'($urandom_range(64, 255));
        2: trim_to($urandom_range(1, sz - 1));
        3: mlen = 16'($urandom);
        4: mlen = 16'(sz - $urandom_range(1, 6));
        default: mlen = 16'(sz + $urandom_range(1, 300));
      endcase
    end
    send_msg(mlen);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // end right at the first header byte, zero length
    msg_q.push_back(8'h00);
    send_msg(16'd0);
    // qr set
    push_header(8'h80);
    trim_to(3);
    send_msg(16'hFFFF);
    // tc set
    push_header(8'h02);
    trim_to(4);
    send_msg(16'hFFFF);
    // opcode not query, ends with the header
    push_header(8'h78);
    trim_to(12);
    send_msg(16'd12);
    // one answer record
    push_header(8'h01);
    msg_q[7] = 8'h01;
    trim_to(12);
    send_msg(16'd12);
    // root name, extreme type, chaos class
    push_header(8'h00);
    push_tail(16'hFFFF, dnsqp_pkg::CLS_CHAOSNET);
    send_msg(16'hFFFF);
    // case folding at the edges of the letter range, then trailing bytes
    push_header(ok_flags());
    msg_q.push_back(8'd8);
    msg_q.push_back(8'h00);
    msg_q.push_back(8'h40);
    msg_q.push_back(8'h41);
    msg_q.push_back(8'h5A);
    msg_q.push_back(8'h5B);
    msg_q.push_back(8'h60);
    msg_q.push_back(8'h7A);
    msg_q.push_back(8'hFF);
    push_label(1);
    push_tail(16'd0, dnsqp_pkg::CLS_INET);
    msg_q.push_back(8'hA5);
    msg_q.push_back(8'h5A);
    send_msg(16'(msg_q.size()));
    // compression pointer
    push_header(8'h00);
    msg_q.push_back(8'hC0);
    msg_q.push_back(8'h0C);
    send_msg(16'hFFFF);
    // label one over the limit
    push_header(8'h00);
    push_label(dnsqp_pkg::MAX_LABEL + 1);
    send_msg(16'hFFFF);
    // message length shorter than the header
    push_header(8'h00);
    push_label(1);
    push_tail(16'd1, dnsqp_pkg::CLS_INET);
    send_msg(16'd11);
    // final mark on a name character
    push_header(8'h00);
    push_label(5);
    trim_to(15);
    send_msg(16'hFFFF);
    // class not served
    push_header(8'h00);
    push_label(3);
    push_tail(16'd1, 16'd2);
    send_msg(16'(msg_q.size()));
    // no room left for type and class
    push_header(8'h00);
    push_label(3);
    push_tail(16'd1, dnsqp_pkg::CLS_INET);
    send_msg(16'(msg_q.size() - 1));
    // message ends inside the class
    push_header(8'h00);
    push_label(2);
    push_tail(16'd28, dnsqp_pkg::CLS_INET);
    trim_to(msg_q.size() - 1);
    send_msg(16'hFFFF);
    // longest name that fits
    push_header(8'h00);
    repeat (3) push_label(dnsqp_pkg::MAX_LABEL);
    push_label(61);
    push_tail(16'd1, dnsqp_pkg::CLS_INET);
    send_msg(16'(msg_q.size()));
    // name one octet too long
    push_header(8'h00);
    repeat (3) push_label(dnsqp_pkg::MAX_LABEL);
    push_label(62);
    push_tail(16'd1, dnsqp_pkg::CLS_INET);
    send_msg(16'hFFFF);

    // hold the output for a long stretch while a long name streams in
    tx_idle_en = 1'b0;
    long_hold_req = 1'b1;
    push_header(8'h00);
    repeat (3) push_label(20);
    push_tail(16'd1, dnsqp_pkg::CLS_INET);
    send_msg(16'(msg_q.size()));
    tx_idle_en = 1'b1;

    while (bytes_sent < ITEMS) begin
      if (bytes_sent > ITEMS * 85 / 100) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      send_random_msg();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d messages in %0d bytes, including header faults, bad labels,",
             msgs_sent, bytes_sent);
    $display("short lengths and early ends; checked %0d name characters and %0d verdicts (%0d ok)",
             n_chars, n_verdicts, n_ok);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dnsqp_pkg.sv
hdl/dns_query_question_parser_top.sv
test/dns_query_question_parser_checker.sv
test/dns_query_question_parser_top_test.sv
